// ===== rtl/acaq_pkg.sv =====
// ----------------------------------------------------------------------------
// acaq_pkg
// Shared types and constants for the per-channel averaging and range check
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package acaq_pkg;

    localparam int CHAN_W   = 3;
    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 5;
    localparam int ERR_W    = 8;
    localparam int VCNT_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // The reciprocal shift covers a 16-bit sum divided by up to 16.
    localparam int DIV_SHIFT = SUM_W + 5;

    localparam logic [VCNT_W-1:0] VCOUNT_MAX = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        EV_ACCUM   = 2'd0,
        EV_AVERAGE = 2'd1,
        EV_INVALID = 2'd2,
        EV_FAULT   = 2'd3
    } event_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [1:0]          event_res;
        logic [SAMPLE_W-1:0] average;
        logic                healthy;
        logic [VCNT_W-1:0]   valid_count;
    } out_item_t;

    typedef struct packed {
        logic [SUM_W-1:0]  running_sum;
        logic [CNT_W-1:0]  sample_count;
        logic [ERR_W-1:0]  error_count;
        logic              health_bit;
        logic [VCNT_W-1:0] average_count;
    } chan_state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_valid;
        logic [SAMPLE_W-1:0] max_valid;
        logic [ERR_W-1:0]    error_limit;
    } cfg_t;

    typedef struct packed {
        event_t            evt;
        logic              healthy;
        logic [VCNT_W-1:0] valid_count;
        logic [SUM_W-1:0]  avg_sum;
    } upd_res_t;

endpackage

`default_nettype wire

// ===== rtl/acaq_ram.sv =====
// ----------------------------------------------------------------------------
// acaq_ram
// Generic single-write, single-read memory with a registered read port.
// A read in the same cycle as a write to the same address returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module acaq_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/acaq_update.sv =====
// ----------------------------------------------------------------------------
// acaq_update
// Next-state rule for one channel: range check, accumulation, window close,
// error counting and fault handling.
// ----------------------------------------------------------------------------
`default_nettype none

module acaq_update #(
    parameter int SAMPLES = 5
) (
    input  acaq_pkg::cfg_t                          cfg,
    input  acaq_pkg::chan_state_t                   cur,
    input  wire logic [acaq_pkg::SAMPLE_W-1:0]      smp,
    output acaq_pkg::chan_state_t                   nxt,
    output acaq_pkg::upd_res_t                      res
);

    import acaq_pkg::*;

    logic              in_range;
    logic [SUM_W-1:0]  sum_inc;
    logic [CNT_W-1:0]  cnt_inc;
    logic              window_done;

    assign in_range    = (smp >= cfg.min_valid) && (smp <= cfg.max_valid);
    assign sum_inc     = cur.running_sum + SUM_W'(smp);
    assign cnt_inc     = cur.sample_count + CNT_W'(1);
    assign window_done = (cnt_inc >= CNT_W'(SAMPLES)) && (cnt_inc != '0);

    always_comb
    begin
        nxt         = cur;
        res.evt     = EV_ACCUM;
        res.avg_sum = '0;
        if (in_range)
        begin
            if (window_done)
            begin
                nxt.running_sum  = '0;
                nxt.sample_count = '0;
                nxt.health_bit   = 1'b1;
                nxt.error_count  = '0;
                if (cur.average_count < VCOUNT_MAX)
                begin
                    nxt.average_count = cur.average_count + VCNT_W'(1);
                end
                res.evt     = EV_AVERAGE;
                res.avg_sum = sum_inc;
            end
            else
            begin
                nxt.running_sum  = sum_inc;
                nxt.sample_count = cnt_inc;
            end
        end
        else if (cur.error_count < cfg.error_limit)
        begin
            nxt.error_count = cur.error_count + ERR_W'(1);
            res.evt         = EV_INVALID;
        end
        else
        begin
            nxt.running_sum   = '0;
            nxt.sample_count  = '0;
            nxt.health_bit    = 1'b0;
            nxt.average_count = '0;
            res.evt           = EV_FAULT;
        end
        res.healthy     = nxt.health_bit;
        res.valid_count = nxt.average_count;
    end

endmodule

`default_nettype wire

// ===== rtl/adc_channel_average_qualifier.sv =====
// ----------------------------------------------------------------------------
// adc_channel_average_qualifier
// Per-channel oversampling averager with range check and fault qualification.
// Channel state lives in one memory that is read, updated and written back.
// ----------------------------------------------------------------------------
//
//  Port group    Direction  Handshake               Payload
//  sample_*      in         sample_valid/stall      in_item_t  (channel, sample)
//  result_*      out        result_valid/stall      out_item_t (one per kept item)
//  cfg_*         in         cfg_we, no wait         cfg_index, cfg_data
//
//  One item is taken every cycle while sample_stall is low. The accepting edge
//  starts the memory read into stage A; when the item moves on, the state is
//  written back and the update result is captured in stage B, from where the
//  reciprocal multiply goes into the output register, stage C.
//  Reset clears a valid bit per channel; a channel that has never been written
//  reads as all zeros, so no clearing pass is needed and items are accepted
//  right after reset. A stall on the result side backs up the three stages and
//  only then reaches sample_stall. Items for a channel beyond CHANNELS are
//  accepted and dropped without a result.
//
`default_nettype none

module adc_channel_average_qualifier #(
    parameter int CHANNELS = 8,
    parameter int SAMPLES  = 5
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  acaq_pkg::in_item_t                      sample_item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output acaq_pkg::out_item_t                     result_item,
    input  wire logic                               cfg_we,
    input  wire logic [acaq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [acaq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import acaq_pkg::*;

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int STATE_W = $bits(chan_state_t);
    localparam int PROD_W  = SUM_W + DIV_SHIFT + 1;
    // Rounded-up reciprocal: exact truncating division for any 16-bit sum.
    localparam logic [DIV_SHIFT:0] DIV_RECIP =
        (DIV_SHIFT + 1)'((2 ** DIV_SHIFT + SAMPLES - 1) / SAMPLES);

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_valid   <= '0;
            cfg_reg.max_valid   <= 12'd4095;
            cfg_reg.error_limit <= 8'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_VALID:   cfg_reg.min_valid   <= cfg_data;
                CFG_MAX_VALID:   cfg_reg.max_valid   <= cfg_data;
                CFG_ERROR_LIMIT: cfg_reg.error_limit <= cfg_data[ERR_W-1:0];
                default:         ;
            endcase
        end
    end

    // Pipeline control. Stage A waits for the memory read, stage B holds the
    // update result, stage C is the output register.
    logic a_vld_reg, b_vld_reg, c_vld_reg;
    logic c_free, b_move, b_free, a_move, a_free;
    logic sample_acc, load_a, chan_ok;

    assign c_free       = !c_vld_reg || !result_stall;
    assign b_move       = b_vld_reg && c_free;
    assign b_free       = !b_vld_reg || b_move;
    assign a_move       = a_vld_reg && b_free;
    assign a_free       = !a_vld_reg || a_move;
    assign sample_stall = !a_free;
    assign sample_acc   = sample_valid && !sample_stall;
    assign chan_ok      = 32'(sample_item.channel) < CHANNELS;
    assign load_a       = sample_acc && chan_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_vld_reg <= load_a;
            end
            if (b_free)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (c_free)
            begin
                c_vld_reg <= b_vld_reg;
            end
        end
    end

    // Stage A payload and the bypass for a write that lands in the same cycle
    // as this item's read.
    logic [CHAN_W-1:0]   a_chan_reg;
    logic [SAMPLE_W-1:0] a_sample_reg;
    logic                byp_hit_reg;
    logic                byp_hit_next;
    chan_state_t         byp_state_reg;
    logic [CH_AW-1:0]    a_idx;
    logic [CH_AW-1:0]    in_idx;
    logic [CHANNELS-1:0] written_reg;

    chan_state_t         cur_state;
    chan_state_t         nxt_state;
    upd_res_t            upd_res;
    logic [STATE_W-1:0]  ram_rd_data;

    assign a_idx        = CH_AW'(a_chan_reg);
    assign in_idx       = CH_AW'(sample_item.channel);
    assign byp_hit_next = a_move && (a_idx == in_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
            written_reg <= '0;
        end
        else
        begin
            if (load_a)
            begin
                byp_hit_reg <= byp_hit_next;
            end
            if (a_move)
            begin
                written_reg[a_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_chan_reg    <= sample_item.channel;
            a_sample_reg  <= sample_item.sample;
            byp_state_reg <= nxt_state;
        end
    end

    acaq_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .we      (a_move),
        .wr_addr (a_idx),
        .wr_data (nxt_state),
        .rd_en   (load_a),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    // A channel never written since reset reads as its reset state of zeros.
    always_comb
    begin
        if (byp_hit_reg)
        begin
            cur_state = byp_state_reg;
        end
        else if (written_reg[a_idx])
        begin
            cur_state = chan_state_t'(ram_rd_data);
        end
        else
        begin
            cur_state = '0;
        end
    end

    acaq_update #(
        .SAMPLES (SAMPLES)
    ) u_update (
        .cfg (cfg_reg),
        .cur (cur_state),
        .smp (a_sample_reg),
        .nxt (nxt_state),
        .res (upd_res)
    );

    // Stage B payload.
    logic [CHAN_W-1:0] b_chan_reg;
    upd_res_t          b_res_reg;

    always_ff @(posedge clk)
    begin
        if (b_free)
        begin
            b_chan_reg <= a_chan_reg;
            b_res_reg  <= upd_res;
        end
    end

    // The average is the sum times the reciprocal of SAMPLES; the sum is zero
    // for every event other than a new average, so the product is too.
    logic [PROD_W-1:0] avg_prod;
    out_item_t         result_next;
    out_item_t         result_reg;

    assign avg_prod = PROD_W'(b_res_reg.avg_sum) * PROD_W'(DIV_RECIP);

    always_comb
    begin
        result_next.out_channel = b_chan_reg;
        result_next.event_res   = b_res_reg.evt;
        result_next.average     = avg_prod[DIV_SHIFT +: SAMPLE_W];
        result_next.healthy     = b_res_reg.healthy;
        result_next.valid_count = b_res_reg.valid_count;
    end

    always_ff @(posedge clk)
    begin
        if (c_free)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = c_vld_reg;
    assign result_item  = result_reg;

    // A fault report always leaves the channel unhealthy with no averages.
    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && (result_reg.event_res == EV_FAULT)
        |-> !result_reg.healthy && (result_reg.valid_count == '0))
        else $error("fault result with health or average count set");

    // A new average always leaves the channel healthy with a nonzero count.
    a_avg_healthy: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && (result_reg.event_res == EV_AVERAGE)
        |-> result_reg.healthy && (result_reg.valid_count != '0))
        else $error("average result without health or count");

    // Only a new average carries a nonzero average field.
    a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_vld_reg && (result_reg.event_res != EV_AVERAGE)
        |-> (result_reg.average == '0))
        else $error("nonzero average on a non-average result");

    // The input side is held back only while stage A is occupied and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> a_vld_reg && b_vld_reg && c_vld_reg && result_stall)
        else $error("input stalled with room in the pipeline");

    // An item leaving stage A is in stage B on the next edge.
    a_a_to_b: assert property (@(posedge clk) disable iff (!rst_n)
        a_move |=> b_vld_reg)
        else $error("item lost between read and update stages");

endmodule

`default_nettype wire

// ===== test/tb_adc_channel_average_qualifier.sv =====
// ----------------------------------------------------------------------------
// tb_adc_channel_average_qualifier
// Self-checking bench for the per-channel averager with range qualification.
// A driver feeds samples from a queue and predicts each result as the sample
// is taken; a monitor compares every result, field by field, with the oldest
// prediction. Both sides idle at random, and the range and fault registers
// are changed between phases while the block is empty.
// ----------------------------------------------------------------------------

module tb_adc_channel_average_qualifier;

    import acaq_pkg::*;

    // These match the parameters the block is built with.
    localparam int CHAN_COUNT = 8;
    localparam int WINDOW_LEN = 5;

    // Cycles with no handshake on either side before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;

    // Margin after the last result for anything that should not appear.
    localparam int SETTLE_CYCLES = 10;

    // Item counts between which neither side idles.
    localparam int STEADY_FROM = 400;
    localparam int STEADY_TO   = 700;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    in_item_t              sample_item  = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_item_t             result_item;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_MIN_VALID;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Samples waiting to be offered, and results predicted but not yet seen.
    in_item_t  pending_samples[$];
    out_item_t expected_results[$];

    // Predictor copy of the range registers and of the per-channel state.
    logic [SAMPLE_W-1:0] win_lo;
    logic [SAMPLE_W-1:0] win_hi;
    logic [ERR_W-1:0]    fault_limit;
    logic [SUM_W-1:0]    chan_sum[CHAN_COUNT];
    logic [CNT_W-1:0]    chan_fill[CHAN_COUNT];
    logic [ERR_W-1:0]    chan_errors[CHAN_COUNT];
    logic                chan_healthy[CHAN_COUNT];
    logic [VCNT_W-1:0]   chan_averages[CHAN_COUNT];

    int unsigned samples_taken = 0;
    int unsigned results_seen  = 0;
    int unsigned failures      = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned event_hits[4] = '{0, 0, 0, 0};
    int unsigned top_count     = 0;

    adc_channel_average_qualifier #(
        .CHANNELS(CHAN_COUNT),
        .SAMPLES (WINDOW_LEN)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample_item (sample_item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_item (result_item),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one sample to the predicted channel state and returns the
    // result the block should give. Returns 0 when the sample is dropped.
    function automatic bit predict_averager(input in_item_t it, output out_item_t res);
        int unsigned ch;
        event_t      evt;
        logic [SAMPLE_W-1:0] avg;
        ch  = it.channel;
        evt = EV_ACCUM;
        avg = '0;
        res = '0;
        // A channel the block was not built with leaves no trace at all.
        if (ch >= CHAN_COUNT)
            return 1'b0;
        if (it.sample >= win_lo && it.sample <= win_hi)
        begin
            chan_sum[ch]  = chan_sum[ch] + it.sample;
            chan_fill[ch] = chan_fill[ch] + 1'b1;
            if (chan_fill[ch] >= WINDOW_LEN)
            begin
                // Truncating division of the window sum.
                avg = SAMPLE_W'(int'(chan_sum[ch]) / int'(chan_fill[ch]));
                chan_sum[ch]     = '0;
                chan_fill[ch]    = '0;
                chan_healthy[ch] = 1'b1;
                chan_errors[ch]  = '0;
                if (chan_averages[ch] != VCOUNT_MAX)
                    chan_averages[ch] = chan_averages[ch] + 1'b1;
                evt = EV_AVERAGE;
            end
        end
        else if (chan_errors[ch] < fault_limit)
        begin
            chan_errors[ch] = chan_errors[ch] + 1'b1;
            evt = EV_INVALID;
        end
        else
        begin
            // Past the limit the channel is faulted; the error count stays
            // where it is, so every further bad sample faults it again.
            chan_sum[ch]      = '0;
            chan_fill[ch]     = '0;
            chan_healthy[ch]  = 1'b0;
            chan_averages[ch] = '0;
            evt = EV_FAULT;
        end
        res.out_channel = it.channel;
        res.event_res   = evt;
        res.average     = avg;
        res.healthy     = chan_healthy[ch];
        res.valid_count = chan_averages[ch];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d, %s is %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // Driver. The predictor runs here, on the edge at which a sample is
    // taken, and the register copy follows the write port on the same edge.
    // A stalled item is held unchanged; between items the driver may idle.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        out_item_t predicted;
        bit        pause_now;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            win_lo      = '0;
            win_hi      = '1;
            fault_limit = 8'd8;
            for (int c = 0; c < CHAN_COUNT; c++)
            begin
                chan_sum[c]      = '0;
                chan_fill[c]     = '0;
                chan_errors[c]   = '0;
                chan_healthy[c]  = 1'b0;
                chan_averages[c] = '0;
            end
        end
        else
        begin
            pause_now = ($urandom_range(99, 0) < 25) &&
                        !(samples_taken >= STEADY_FROM && samples_taken < STEADY_TO);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_VALID:   win_lo = cfg_data;
                    CFG_MAX_VALID:   win_hi = cfg_data;
                    CFG_ERROR_LIMIT: fault_limit = cfg_data[ERR_W-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                samples_taken++;
                if (predict_averager(sample_item, predicted))
                    expected_results.push_back(predicted);
            end
            if (!(sample_valid && sample_stall))
            begin
                if (pending_samples.size() != 0 && !pause_now)
                begin
                    sample_valid <= 1'b1;
                    sample_item  <= pending_samples.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every result taken is matched against the oldest prediction,
    // and the stall toward the block is redrawn each cycle.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("channel", result_item.out_channel, want.out_channel);
                    check_field("event", result_item.event_res, want.event_res);
                    check_field("average", result_item.average, want.average);
                    check_field("healthy", result_item.healthy, want.healthy);
                    check_field("valid count", result_item.valid_count, want.valid_count);
                    event_hits[want.event_res]++;
                    if (want.valid_count > top_count)
                        top_count = want.valid_count;
                end
            end
            result_stall <= ($urandom_range(99, 0) < 25) &&
                            !(results_seen >= STEADY_FROM && results_seen < STEADY_TO);
        end
    end

    // Watchdog. A lost or stuck result shows up here as a long quiet spell.
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Samples are only queued on the falling edge, away from the
    // driver and monitor.
    task automatic add_sample(input int unsigned ch, input int unsigned value);
        pending_samples.push_back(in_item_t'{channel: CHAN_W'(ch),
                                             sample: SAMPLE_W'(value)});
    endtask

    // Returns once every queued sample has been taken and every predicted
    // result has come back, which also makes the sender wait for the block.
    task automatic drain_results();
        @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // New range and fault limit, written only once the block is empty.
    task automatic set_limits(input int unsigned lo, input int unsigned hi,
                              input int unsigned lim);
        drain_results();
        write_reg(CFG_MIN_VALID, CFG_DATA_W'(lo));
        write_reg(CFG_MAX_VALID, CFG_DATA_W'(hi));
        write_reg(CFG_ERROR_LIMIT, CFG_DATA_W'(lim));
        @(negedge clk);
        settings_used++;
    endtask

    // Mostly in-window samples so that windows complete, with a share of
    // values at and just past the window edges and some plain noise. A narrow
    // phase keeps to two channels so those get long histories.
    task automatic queue_random(input int count, input logic [SAMPLE_W-1:0] lo,
                                input logic [SAMPLE_W-1:0] hi, input bit narrow,
                                input int unsigned base_ch);
        int unsigned         pick;
        int unsigned         ch;
        logic [SAMPLE_W-1:0] s;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70 && lo <= hi)
                s = $urandom_range(hi, lo);
            else if (pick < 85)
            begin
                case ($urandom_range(3, 0))
                    0: s = lo;
                    1: s = hi;
                    2: s = lo - 1'b1;
                    default: s = hi + 1'b1;
                endcase
            end
            else
                s = $urandom_range(4095, 0);
            ch = narrow ? base_ch + $urandom_range(1, 0) : $urandom_range(CHAN_COUNT - 1, 0);
            add_sample(ch, s);
        end
    endtask

    initial
    begin : stimulus
        int unsigned lo;
        int unsigned hi;
        int unsigned lim;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a window of all zeros on channel 0 and of full-scale
        // readings on channel 7, which is the largest sum a window can hold.
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            add_sample(0, 0);
            add_sample(7, 4095);
        end

        // With a zero limit the first bad sample faults the channel, and the
        // next one faults it again. Samples on the window edges are accepted.
        set_limits(100, 200, 0);
        add_sample(1, 50);
        add_sample(1, 4095);
        add_sample(1, 100);
        add_sample(1, 200);
        add_sample(2, 99);
        add_sample(2, 201);

        // An inverted window rejects everything: two counted, then faults.
        set_limits(3000, 1000, 2);
        add_sample(3, 2000);
        add_sample(3, 3000);
        add_sample(3, 1000);
        add_sample(3, 0);

        // Largest fault limit, with both converter extremes just outside.
        set_limits(1, 4094, 255);
        add_sample(4, 0);
        add_sample(4, 4095);
        add_sample(4, 1);
        add_sample(4, 4094);

        // Random phases, each under its own register setting. The first three
        // pin the registers to their extremes.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: begin lo = 0;    hi = 0;    lim = 0;   end
                1: begin lo = 4095; hi = 4095; lim = 255; end
                2: begin lo = 4095; hi = 0;    lim = 3;   end
                default:
                begin
                    lo = $urandom_range(2500, 0);
                    hi = lo + $urandom_range(1595, 0);
                    case ($urandom_range(3, 0))
                        0: lim = 0;
                        1: lim = $urandom_range(3, 1);
                        2: lim = $urandom_range(12, 4);
                        default: lim = $urandom_range(255, 0);
                    endcase
                end
            endcase
            set_limits(lo, hi, lim);
            queue_random(6, lo, hi, p[0], (p % 4) * 2);
        end

        // With the full range every sample counts, so a long run on channel 6
        // completes more than 256 windows and drives its completed-average
        // count into saturation.
        set_limits(0, 4095, 8);
        for (int i = 0; i < 1285; i++)
        begin
            add_sample(6, $urandom_range(4095, 0));
        end

        // A one-value window at the top of the scale: the saturated channel
        // faults at once and starts over.
        set_limits(4095, 4095, 0);
        add_sample(6, 0);
        add_sample(6, 4095);
        add_sample(6, 4094);
        queue_random(10, 12'hFFF, 12'hFFF, 1'b0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d samples under %0d register settings.",
                 results_seen, samples_taken, settings_used + 1);
        $display("Events: %0d accumulate, %0d average, %0d invalid, %0d fault; peak count %0d.",
                 event_hits[EV_ACCUM], event_hits[EV_AVERAGE], event_hits[EV_INVALID],
                 event_hits[EV_FAULT], top_count);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/acaq_pkg.sv
rtl/acaq_ram.sv
rtl/acaq_update.sv
rtl/adc_channel_average_qualifier.sv
test/tb_adc_channel_average_qualifier.sv
